// ----- rtl/core/lpr_pkg.sv -----
// Package for the line pixel rasterizer: coordinate widths, stream widths and
// the structs passed between the setup, stepper and top-level modules.
// No dependencies.
`default_nettype none

package lpr_pkg;

    localparam int COORD_BITS = 12;
    localparam int DELTA_W    = COORD_BITS + 1;
    localparam int STRAIGHT_W = COORD_BITS + 1;
    localparam int ERR_W      = COORD_BITS + 3;

    localparam int S_TDATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [COORD_BITS-1:0] mag_t;
    typedef logic signed [ERR_W-1:0]      err_t;
    typedef logic        [STRAIGHT_W-1:0] straight_t;

    // Everything a start transfer loads into the stepper.
    typedef struct packed {
        coord_t    origin_x;
        coord_t    origin_y;
        logic      single;
        logic      x_major;
        logic      neg_x;
        logic      neg_y;
        mag_t      major_len;
        err_t      err_init;
        err_t      diag_inc;
        straight_t straight_inc;
    } line_init_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
    } pixel_t;

endpackage

`default_nettype wire

// ----- rtl/core/lpr_setup.sv -----
// Line setup: deltas, octant selection and Bresenham error terms for a start
// transfer. Purely combinational. Depends on lpr_pkg.
`default_nettype none

module lpr_setup import lpr_pkg::*; (
    input  wire coord_t     x_start,
    input  wire coord_t     y_start,
    input  wire coord_t     x_end,
    input  wire coord_t     y_end,
    output line_init_t      init
);

    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic signed [DELTA_W-1:0] dx_abs;
    logic signed [DELTA_W-1:0] dy_abs;
    mag_t                      ax;
    mag_t                      ay;
    mag_t                      maj;
    mag_t                      mnr;
    err_t                      maj_e;
    err_t                      mnr_e;

    always_comb begin
        dx     = DELTA_W'(x_end) - DELTA_W'(x_start);
        dy     = DELTA_W'(y_end) - DELTA_W'(y_start);
        dx_abs = dx[DELTA_W-1] ? -dx : dx;
        dy_abs = dy[DELTA_W-1] ? -dy : dy;
        ax     = dx_abs[COORD_BITS-1:0];
        ay     = dy_abs[COORD_BITS-1:0];

        // Ties go to the x axis as the major axis.
        init.x_major = (ax >= ay);
        maj          = init.x_major ? ax : ay;
        mnr          = init.x_major ? ay : ax;
        maj_e        = signed'(ERR_W'(maj));
        mnr_e        = signed'(ERR_W'(mnr));

        init.origin_x     = x_start;
        init.origin_y     = y_start;
        init.single       = (dx == '0) && (dy == '0);
        init.neg_x        = dx[DELTA_W-1];
        init.neg_y        = dy[DELTA_W-1];
        init.major_len    = maj;
        init.err_init     = (mnr_e <<< 1) - maj_e;
        init.diag_inc     = (mnr_e - maj_e) <<< 1;
        init.straight_inc = {mnr, 1'b0};
    end

endmodule

`default_nettype wire

// ----- rtl/core/lpr_stepper.sv -----
// Bresenham stepper: holds the running line state and produces one pixel per
// start transfer and per step transfer while busy. Depends on lpr_pkg.
`default_nettype none

module lpr_stepper import lpr_pkg::*; (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        start_en,
    input  wire        step_en,
    input  line_init_t init,
    output logic       busy,
    output pixel_t     pix
);

    logic      busy_reg,     busy_next;
    logic      x_major_reg,  x_major_next;
    logic      neg_x_reg,    neg_x_next;
    logic      neg_y_reg,    neg_y_next;
    mag_t      major_pos_reg,   major_pos_next;
    mag_t      major_limit_reg, major_limit_next;
    err_t      err_reg,      err_next;
    err_t      diag_reg,     diag_next;
    straight_t straight_reg, straight_next;
    coord_t    cur_x_reg,    cur_x_next;
    coord_t    cur_y_reg,    cur_y_next;

    logic      take_diag;
    logic      fin;
    logic      move_x;
    logic      move_y;
    mag_t      pos_inc;
    coord_t    step_x;
    coord_t    step_y;
    coord_t    new_x;
    coord_t    new_y;

    always_comb begin
        take_diag = !err_reg[ERR_W-1];
        pos_inc   = major_pos_reg + mag_t'(1);
        fin       = (pos_inc >= major_limit_reg);
        move_x    = x_major_reg || take_diag;
        move_y    = !x_major_reg || take_diag;
        step_x    = neg_x_reg ? coord_t'(-1) : coord_t'(1);
        step_y    = neg_y_reg ? coord_t'(-1) : coord_t'(1);
        new_x     = move_x ? cur_x_reg + step_x : cur_x_reg;
        new_y     = move_y ? cur_y_reg + step_y : cur_y_reg;

        busy_next        = busy_reg;
        x_major_next     = x_major_reg;
        neg_x_next       = neg_x_reg;
        neg_y_next       = neg_y_reg;
        major_pos_next   = major_pos_reg;
        major_limit_next = major_limit_reg;
        err_next         = err_reg;
        diag_next        = diag_reg;
        straight_next    = straight_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;

        if (start_en) begin
            busy_next        = !init.single;
            x_major_next     = init.x_major;
            neg_x_next       = init.neg_x;
            neg_y_next       = init.neg_y;
            major_pos_next   = '0;
            major_limit_next = init.major_len;
            err_next         = init.err_init;
            diag_next        = init.diag_inc;
            straight_next    = init.straight_inc;
            cur_x_next       = init.origin_x;
            cur_y_next       = init.origin_y;
        end else if (step_en && busy_reg) begin
            busy_next      = !fin;
            major_pos_next = pos_inc;
            err_next       = err_reg + (take_diag ? diag_reg : signed'(ERR_W'(straight_reg)));
            cur_x_next     = new_x;
            cur_y_next     = new_y;
        end

        if (start_en) begin
            pix.x    = init.origin_x;
            pix.y    = init.origin_y;
            pix.last = init.single;
        end else begin
            pix.x    = new_x;
            pix.y    = new_y;
            pix.last = fin;
        end
        busy = busy_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        x_major_reg     <= x_major_next;
        neg_x_reg       <= neg_x_next;
        neg_y_reg       <= neg_y_next;
        major_pos_reg   <= major_pos_next;
        major_limit_reg <= major_limit_next;
        err_reg         <= err_next;
        diag_reg        <= diag_next;
        straight_reg    <= straight_next;
        cur_x_reg       <= cur_x_next;
        cur_y_reg       <= cur_y_next;
    end

    // A running line never sits at or past its end point.
    a_pos_below_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (major_pos_reg < major_limit_reg))
        else $error("major position reached the limit while busy");

    // A degenerate line leaves the block idle.
    a_single_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (start_en && init.single) |=> !busy_reg)
        else $error("single-point line left the stepper busy");

    // The pixel flagged last ends the line.
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (!start_en && step_en && busy_reg && fin) |=> !busy_reg)
        else $error("stepper still busy after the last pixel");

    // The diagonal increment is never positive.
    a_diag_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (diag_reg[ERR_W-1] || (diag_reg == '0)))
        else $error("diagonal increment is positive");

endmodule

`default_nettype wire

// ----- rtl/core/line_pixel_rasterizer.sv -----
// A pixel appears on the m_ side in the cycle after its input transfer.
// Throughput: one input transfer and one pixel per cycle while m_tready is
// high, set by the single output register, which refills in the same cycle
// it is drained. A step transfer while no line is running produces no pixel.
// Reset (aresetn low, synchronous) clears the running line and the output
// valid flag. Depends on lpr_pkg, lpr_setup and lpr_stepper.
`default_nettype none

module line_pixel_rasterizer import lpr_pkg::*; (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire [S_TDATA_W-1:0]  s_tdata,   // x_start, y_start, x_end, y_end
    input  wire                  s_tuser,   // op
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // pixel_x, pixel_y
    output logic                 m_tlast
);

    line_init_t init;
    pixel_t     pix;
    logic       busy;
    logic       in_xfer;
    logic       start_en;
    logic       step_en;
    logic       produce;

    logic       m_valid_reg, m_valid_next;
    pixel_t     m_pix_reg,   m_pix_next;

    lpr_setup u_setup (
        .x_start (coord_t'(s_tdata[COORD_BITS-1:0])),
        .y_start (coord_t'(s_tdata[2*COORD_BITS-1:COORD_BITS])),
        .x_end   (coord_t'(s_tdata[3*COORD_BITS-1:2*COORD_BITS])),
        .y_end   (coord_t'(s_tdata[4*COORD_BITS-1:3*COORD_BITS])),
        .init    (init)
    );

    lpr_stepper u_stepper (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start_en (start_en),
        .step_en  (step_en),
        .init     (init),
        .busy     (busy),
        .pix      (pix)
    );

    always_comb begin
        s_tready = !m_valid_reg || m_tready;
        in_xfer  = s_tvalid && s_tready;
        start_en = in_xfer && (s_tuser == OP_START);
        step_en  = in_xfer && (s_tuser == OP_STEP);
        produce  = start_en || (step_en && busy);

        m_pix_next = m_pix_reg;
        if (produce) begin
            m_valid_next = 1'b1;
            m_pix_next   = pix;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_pix_reg <= m_pix_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_pix_reg.y, m_pix_reg.x});
    assign m_tlast  = m_pix_reg.last;

endmodule

`default_nettype wire
